>>> hdl/abrms_pkg.sv
package abrms_pkg;

    localparam int DEPTH     = 32768;
    localparam int MAX_BLOCK = 256;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 15;
    localparam int FILL_W   = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(32767);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int SQ_W   = 2 * SAMPLE_W - 1;
    localparam int SUM_W  = SQ_W + ((MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 0);
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int DIV_W  = 2 * ROOT_W;
    localparam int STEP_W = $clog2(ROOT_W);

    localparam int OUT_DATA_W = SAMPLE_W + LEVEL_W + FILL_W + 1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_lvl_sts;

endpackage

>>> hdl/abrms_ram.sv
module abrms_ram #(
    parameter int W = 16,
    parameter int D = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                   i_wdata,
    input  logic                           i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                   o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> hdl/abrms_lvl.sv
module abrms_lvl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [abrms_pkg::SUM_W-1:0]    i_sum,
    input  logic [abrms_pkg::CNT_W-1:0]    i_count,
    output abrms_pkg::t_lvl_sts            o_sts,
    output logic [abrms_pkg::LEVEL_W-1:0]  o_level
);

    import abrms_pkg::*;

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_DIV  = 4'b0010,
        L_SQRT = 4'b0100,
        L_DONE = 4'b1000
    } t_lvl_state;

    t_lvl_state r_state, n_state;

    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_drem;
    logic [DIV_W-1:0]  r_work;
    logic [ROOT_W:0]   r_srem;
    logic [ROOT_W-1:0] r_root;

    logic [CNT_W-1:0]  v_drem;
    logic [DIV_W-1:0]  v_quo;
    logic [CNT_W:0]    v_dtry;
    logic [ROOT_W+2:0] v_stry;
    logic [ROOT_W+2:0] v_trial;
    logic              v_sbit;
    logic              v_last;

    // two restoring division steps per cycle
    always_comb begin
        v_drem = r_drem;
        v_quo  = r_work;
        v_dtry = '0;
        for (int k = 0; k < 2; k++) begin
            v_dtry = {v_drem, v_quo[DIV_W-1]};
            v_quo  = {v_quo[DIV_W-2:0], 1'b0};
            if (v_dtry >= {1'b0, r_den}) begin
                v_dtry   = v_dtry - {1'b0, r_den};
                v_quo[0] = 1'b1;
            end
            v_drem = v_dtry[CNT_W-1:0];
        end
    end

    // one root digit per cycle
    always_comb begin
        v_stry  = {r_srem, r_work[DIV_W-1 -: 2]};
        v_trial = {1'b0, r_root, 2'b01};
        v_sbit  = (v_stry >= v_trial);
    end

    assign v_last = (r_step == STEP_W'(ROOT_W - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_state = L_DIV;
                end
            end
            L_DIV: begin
                if (v_last) begin
                    n_state = L_SQRT;
                end
            end
            L_SQRT: begin
                if (v_last) begin
                    n_state = L_DONE;
                end
            end
            L_DONE: begin
                n_state = L_IDLE;
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == L_IDLE || v_last) begin
                r_step <= '0;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    r_work <= DIV_W'(i_sum);
                    r_drem <= '0;
                    r_den  <= i_count;
                end
            end
            L_DIV: begin
                r_drem <= v_drem;
                r_work <= v_quo;
                if (v_last) begin
                    r_srem <= '0;
                    r_root <= '0;
                end
            end
            L_SQRT: begin
                r_work <= {r_work[DIV_W-3:0], 2'b00};
                r_root <= {r_root[ROOT_W-2:0], v_sbit};
                if (v_sbit) begin
                    r_srem <= (ROOT_W+1)'(v_stry - v_trial);
                end else begin
                    r_srem <= v_stry[ROOT_W:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_level    = (r_root > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX : r_root[LEVEL_W-1:0];
    assign o_sts.busy = (r_state != L_IDLE);
    assign o_sts.done = (r_state == L_DONE);

endmodule

>>> hdl/audio_block_rms_and_sample_fifo.sv
// Block level meter with a sample ring. Each input word is a push (tuser 0) carrying the left
// sample of a stereo frame, or a pop (tuser 1); tlast on a push closes the capture block.
// Every word gives exactly one output word holding the popped sample, the level of the last
// completed block, the ring fill count and an overwrite flag. The ring lives in a single
// dual-port RAM; when it is full a push overwrites the oldest sample and flags it. Only the
// first MAX_BLOCK frames of a block are summed and stored. The block handles one word at a
// time: a pop or an ordinary push passes through its read or sum state to the output
// register, a pop from an empty ring goes there directly, and a push that closes a non-empty
// block waits on the level unit, which runs the mean division two bits per cycle and then the
// square root one digit per cycle. Input is taken again in the cycle after the output
// register loads. A finished word waits in the output register while the next one is taken.
module audio_block_rms_and_sample_fifo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // left_sample
    input  logic        s_axis_tuser,   // action
    input  logic        s_axis_tlast,   // last_in_block
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [abrms_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // out_sample, level, fill_count,
                                                             // dropped_oldest
    output logic        m_axis_tuser    // sample_valid
);

    import abrms_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_LVL  = 5'b00100,
        S_RD   = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [OCC_W-1:0]    r_occ;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_frames;
    logic [LEVEL_W-1:0]  r_level;

    logic [SQ_W-1:0]     r_sq;
    logic                r_counted;
    logic                r_last;
    logic                r_res_valid;
    logic                r_res_drop;
    logic [SAMPLE_W-1:0] r_res_sample;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                  r_m_user;

    logic                    v_acc;
    logic                    v_push;
    logic                    v_pop;
    logic                    v_count_ok;
    logic                    v_full;
    logic                    v_load;
    logic [SUM_W-1:0]        n_sum;
    logic [PTR_W-1:0]        v_wr_next;
    logic [PTR_W-1:0]        v_rd_next;
    logic signed [SAMPLE_W-1:0]   v_s;
    logic signed [2*SAMPLE_W-1:0] v_prod;

    logic [SAMPLE_W-1:0] ram_rdata;
    logic                lvl_start;
    t_lvl_sts            lvl_sts;
    logic [LEVEL_W-1:0]  lvl_level;

    assign s_axis_tready = (r_state == S_IDLE);
    assign v_acc         = s_axis_tvalid && s_axis_tready;
    assign v_push        = v_acc && !s_axis_tuser;
    assign v_pop         = v_acc && s_axis_tuser && (r_occ != '0);
    assign v_count_ok    = (r_frames < CNT_W'(MAX_BLOCK));
    assign v_full        = (r_occ == OCC_W'(DEPTH));
    assign v_wr_next     = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign v_rd_next     = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign v_s           = s_axis_tdata[SAMPLE_W-1:0];
    assign v_prod        = v_s * v_s;
    assign n_sum         = r_counted ? r_sum + SUM_W'(r_sq) : r_sum;
    assign v_load        = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);
    assign lvl_start     = (r_state == S_SUM) && r_last && (r_frames != '0);

    abrms_ram #(
        .W (SAMPLE_W),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (v_push && v_count_ok),
        .i_waddr (r_wr_ptr),
        .i_wdata (s_axis_tdata[SAMPLE_W-1:0]),
        .i_re    (v_pop),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    abrms_lvl u_lvl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lvl_start),
        .i_sum   (n_sum),
        .i_count (r_frames),
        .o_sts   (lvl_sts),
        .o_level (lvl_level)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (v_acc) begin
                    if (!s_axis_tuser) begin
                        n_state = S_SUM;
                    end else if (r_occ != '0) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SUM: begin
                n_state = lvl_start ? S_LVL : S_OUT;
            end
            S_LVL: begin
                if (lvl_sts.done) begin
                    n_state = S_OUT;
                end
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (v_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_occ     <= '0;
            r_sum     <= '0;
            r_frames  <= '0;
            r_level   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (v_push && v_count_ok) begin
                r_wr_ptr <= v_wr_next;
                r_frames <= r_frames + 1'b1;
                if (v_full) begin
                    r_rd_ptr <= v_rd_next;
                end else begin
                    r_occ <= r_occ + 1'b1;
                end
            end
            if (v_pop) begin
                r_rd_ptr <= v_rd_next;
                r_occ    <= r_occ - 1'b1;
            end
            if (r_state == S_SUM) begin
                if (r_last) begin
                    r_sum    <= '0;
                    r_frames <= '0;
                end else begin
                    r_sum <= n_sum;
                end
            end
            if (r_state == S_LVL && lvl_sts.done) begin
                r_level <= lvl_level;
            end
            if (v_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_acc) begin
            r_sq         <= v_prod[SQ_W-1:0];
            r_counted    <= !s_axis_tuser && v_count_ok;
            r_last       <= !s_axis_tuser && s_axis_tlast;
            r_res_valid  <= s_axis_tuser && (r_occ != '0);
            r_res_drop   <= !s_axis_tuser && v_count_ok && v_full;
            r_res_sample <= '0;
        end
        if (r_state == S_RD) begin
            r_res_sample <= ram_rdata;
        end
        if (v_load) begin
            r_m_data <= {r_res_drop, FILL_W'(r_occ), r_level, r_res_sample};
            r_m_user <= r_res_valid;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(DEPTH))
        else $error("ring occupancy above depth");

    a_frames_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames <= CNT_W'(MAX_BLOCK))
        else $error("block frame count above limit");

    a_ready_lvl_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !lvl_sts.busy)
        else $error("input taken while level unit busy");

    a_pop_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> !m_axis_tdata[47])
        else $error("pop result flagged as overwrite");

    a_pop_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_pop |=> (r_occ == $past(r_occ) - 1'b1))
        else $error("pop did not lower occupancy");
`endif

endmodule
